// ===== design/pngu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and codes for the PNG scanline unfilter to BGRA unit.
// ----------------------------------------------------------------------------
package pngu_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 1'd0,
    CFG_COLOR_MODE  = 1'd1
  } cfg_reg_t;

  // color modes, code + 1 is the bytes per pixel
  typedef enum logic [1:0] {
    MODE_GRAY       = 2'd0,
    MODE_GRAY_ALPHA = 2'd1,
    MODE_RGB        = 2'd2,
    MODE_RGBA       = 2'd3
  } color_mode_t;

  // row filter types
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic        is_filter;
    logic [7:0]  data;
    logic [1:0]  lane;
    filter_t     filter;
    logic        first_row;
    color_mode_t mode;
    logic        last_byte;
    logic        end_of_row;
  } op_t;

endpackage

// ===== design/pngu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu interfaces
// Byte input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface pngu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_image;

  modport source(output valid, data_byte, first_of_image, input ready);
  modport sink(input valid, data_byte, first_of_image, output ready);
endinterface

interface pngu_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic       end_of_row;

  modport source(output valid, blue, green, red, alpha, end_of_row, input ready);
  modport sink(input valid, blue, green, red, alpha, end_of_row, output ready);
endinterface

interface pngu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pngu_pkg::CFG_IDX_W-1:0] index;
  logic [pngu_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/pngu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_front
// Holds the configuration registers, tracks row and pixel position and tags
// each accepted byte as a filter byte or a data byte with its store slot.
// ----------------------------------------------------------------------------
module pngu_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int COL_W     = 12
) (
  input  logic                clk,
  input  logic                rst,
  pngu_byte_if.sink           byte_in,
  pngu_cfg_if.sink            cfg,
  output logic                push_valid,
  output pngu_pkg::op_t       push_op,
  output logic [COL_W-1:0]    push_col,
  input  logic                push_ready
);
  import pngu_pkg::*;

  logic [CFG_DATA_W-1:0] image_width;
  color_mode_t           color_mode;
  logic                  awaiting_filter_byte;
  logic                  on_first_row;
  filter_t               row_filter;
  logic [COL_W-1:0]      pixel_column;
  logic [1:0]            byte_in_pixel;

  logic                  awaiting_filter_byte_next;
  logic                  on_first_row_next;
  filter_t               row_filter_next;
  logic [COL_W-1:0]      pixel_column_next;
  logic [1:0]            byte_in_pixel_next;

  logic                  accept;
  logic                  take_filter;
  logic                  first_row_now;
  logic [16:0]           width_ext;
  logic [16:0]           eff_width;
  logic [16:0]           col_inc;
  logic                  pixel_done;
  logic                  row_done;
  filter_t               code;

  assign byte_in.ready = push_ready;
  assign push_valid    = byte_in.valid;
  assign accept        = byte_in.valid && push_ready;
  assign cfg.ready     = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_DATA_W'(1);
      color_mode  <= MODE_RGBA;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH: image_width <= cfg.data;
        CFG_COLOR_MODE:  color_mode  <= color_mode_t'(cfg.data[1:0]);
        default: ;
      endcase
    end
  end

  // classify the incoming byte
  always_comb begin
    take_filter   = byte_in.first_of_image || awaiting_filter_byte;
    first_row_now = byte_in.first_of_image || on_first_row;
    width_ext     = 17'(image_width);
    if (width_ext == 17'd0) begin
      eff_width = 17'd1;
    end else if (width_ext > 17'(MAX_WIDTH)) begin
      eff_width = 17'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    col_inc    = 17'(pixel_column) + 17'd1;
    pixel_done = (byte_in_pixel >= 2'(color_mode));
    row_done   = pixel_done && (col_inc >= eff_width);
    if (byte_in.data_byte <= 8'(FLT_PAETH)) begin
      code = filter_t'(byte_in.data_byte[2:0]);
    end else begin
      code = FLT_NONE;
    end

    push_op.is_filter  = take_filter;
    push_op.data       = byte_in.data_byte;
    push_op.lane       = byte_in_pixel;
    push_op.filter     = row_filter;
    push_op.first_row  = first_row_now;
    push_op.mode       = color_mode;
    push_op.last_byte  = !take_filter && pixel_done;
    push_op.end_of_row = !take_filter && row_done;
    push_col           = pixel_column;
  end

  // position tracking
  always_comb begin
    awaiting_filter_byte_next = awaiting_filter_byte;
    on_first_row_next         = first_row_now;
    row_filter_next           = row_filter;
    pixel_column_next         = pixel_column;
    byte_in_pixel_next        = byte_in_pixel;
    if (take_filter) begin
      awaiting_filter_byte_next = 1'b0;
      row_filter_next           = code;
      pixel_column_next         = '0;
      byte_in_pixel_next        = '0;
    end else if (pixel_done) begin
      byte_in_pixel_next = '0;
      if (row_done) begin
        awaiting_filter_byte_next = 1'b1;
        on_first_row_next         = 1'b0;
        pixel_column_next         = '0;
      end else begin
        pixel_column_next = col_inc[COL_W-1:0];
      end
    end else begin
      byte_in_pixel_next = byte_in_pixel + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_filter_byte <= 1'b1;
      on_first_row         <= 1'b1;
      row_filter           <= FLT_NONE;
      pixel_column         <= '0;
      byte_in_pixel        <= '0;
    end else if (accept) begin
      awaiting_filter_byte <= awaiting_filter_byte_next;
      on_first_row         <= on_first_row_next;
      row_filter           <= row_filter_next;
      pixel_column         <= pixel_column_next;
      byte_in_pixel        <= byte_in_pixel_next;
    end
  end

endmodule

// ===== design/pngu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_fifo
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module pngu_fifo #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data,
  input  logic              pop
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/pngu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_back
// Reads the row above from the line store, undoes the row filter one byte
// per cycle unless pixel_out stalls, writes the row back, emits BGRA pixels.
// ----------------------------------------------------------------------------
module pngu_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int COL_W     = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pngu_pkg::op_t    q_op,
  input  logic [COL_W-1:0] q_col,
  output logic             q_pop,
  pngu_pixel_if.source     pixel_out
);
  import pngu_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH * 4;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic [7:0]        line_store [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  logic              exec_valid;
  op_t               exec_op;
  logic [COL_W-1:0]  exec_col;

  logic [31:0]       left_pixel;
  logic [31:0]       upper_left_pixel;
  logic [31:0]       assembling_pixel;
  logic [31:0]       left_pixel_next;
  logic [31:0]       upper_left_pixel_next;
  logic [31:0]       assembling_pixel_next;

  logic              out_valid;
  logic [7:0]        out_blue;
  logic [7:0]        out_green;
  logic [7:0]        out_red;
  logic [7:0]        out_alpha;
  logic              out_end_of_row;
  logic [7:0]        fmt_blue;
  logic [7:0]        fmt_green;
  logic [7:0]        fmt_red;
  logic [7:0]        fmt_alpha;

  logic              out_free;
  logic              fire;
  logic              store_write;
  logic              emit;
  logic [4:0]        lane_pos;
  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        ab_sum;
  logic signed [9:0] diff_bc;
  logic signed [9:0] diff_ac;
  logic signed [9:0] diff_sum;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        pred;
  logic [7:0]        recon;

  // handshake between queue, execute stage and output register
  assign out_free    = !out_valid || pixel_out.ready;
  assign fire        = exec_valid &&
                       (exec_op.is_filter || !exec_op.last_byte || out_free);
  assign q_pop       = q_valid && (!exec_valid || fire);
  assign store_write = fire && !exec_op.is_filter;
  assign emit        = store_write && exec_op.last_byte;
  assign rd_addr     = ADDR_W'({q_col, q_op.lane});
  assign wr_addr     = ADDR_W'({exec_col, exec_op.lane});

  // line store, read as a byte leaves the queue
  always_ff @(posedge clk) begin
    if (store_write) begin
      line_store[wr_addr] <= recon;
    end
    if (q_pop) begin
      rd_data <= (store_write && (wr_addr == rd_addr)) ? recon : line_store[rd_addr];
    end
  end

  // execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
    end else if (q_pop) begin
      exec_valid <= 1'b1;
    end else if (fire) begin
      exec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      exec_op  <= q_op;
      exec_col <= q_col;
    end
  end

  // neighbors and predictor
  always_comb begin
    lane_pos = {exec_op.lane, 3'b000};
    a        = left_pixel[lane_pos +: 8];
    b        = exec_op.first_row ? 8'd0 : rd_data;
    c        = upper_left_pixel[lane_pos +: 8];
    ab_sum   = 9'(a) + 9'(b);
    diff_bc  = 10'(b) - 10'(c);
    diff_ac  = 10'(a) - 10'(c);
    diff_sum = diff_bc + diff_ac;
    pa       = (diff_bc < 0) ? 10'(-diff_bc) : 10'(diff_bc);
    pb       = (diff_ac < 0) ? 10'(-diff_ac) : 10'(diff_ac);
    pc       = (diff_sum < 0) ? 10'(-diff_sum) : 10'(diff_sum);
    unique case (exec_op.filter)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = ab_sum[8:1];
      FLT_PAETH: begin
        if ((pa <= pb) && (pa <= pc)) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:   pred = 8'd0;
    endcase
    recon = exec_op.data + pred;

    left_pixel_next                      = left_pixel;
    upper_left_pixel_next                = upper_left_pixel;
    assembling_pixel_next                = assembling_pixel;
    left_pixel_next[lane_pos +: 8]       = recon;
    upper_left_pixel_next[lane_pos +: 8] = b;
    assembling_pixel_next[lane_pos +: 8] = recon;
  end

  // pixel format to bgra
  always_comb begin
    unique case (exec_op.mode)
      MODE_GRAY: begin
        fmt_blue  = assembling_pixel_next[7:0];
        fmt_green = assembling_pixel_next[7:0];
        fmt_red   = assembling_pixel_next[7:0];
        fmt_alpha = OPAQUE_ALPHA;
      end
      MODE_GRAY_ALPHA: begin
        fmt_blue  = assembling_pixel_next[7:0];
        fmt_green = assembling_pixel_next[7:0];
        fmt_red   = assembling_pixel_next[7:0];
        fmt_alpha = assembling_pixel_next[15:8];
      end
      MODE_RGB: begin
        fmt_blue  = assembling_pixel_next[23:16];
        fmt_green = assembling_pixel_next[15:8];
        fmt_red   = assembling_pixel_next[7:0];
        fmt_alpha = OPAQUE_ALPHA;
      end
      default: begin
        fmt_blue  = assembling_pixel_next[23:16];
        fmt_green = assembling_pixel_next[15:8];
        fmt_red   = assembling_pixel_next[7:0];
        fmt_alpha = assembling_pixel_next[31:24];
      end
    endcase
  end

  // neighbor and pixel registers, cleared by each filter byte
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      assembling_pixel <= '0;
    end else if (fire) begin
      if (exec_op.is_filter) begin
        left_pixel       <= '0;
        upper_left_pixel <= '0;
        assembling_pixel <= '0;
      end else begin
        left_pixel       <= left_pixel_next;
        upper_left_pixel <= upper_left_pixel_next;
        assembling_pixel <= assembling_pixel_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_blue       <= fmt_blue;
      out_green      <= fmt_green;
      out_red        <= fmt_red;
      out_alpha      <= fmt_alpha;
      out_end_of_row <= exec_op.end_of_row;
    end
  end

  assign pixel_out.valid      = out_valid;
  assign pixel_out.blue       = out_blue;
  assign pixel_out.green      = out_green;
  assign pixel_out.red        = out_red;
  assign pixel_out.alpha      = out_alpha;
  assign pixel_out.end_of_row = out_end_of_row;

endmodule

// ===== design/png_scanline_unfilter_to_bgra_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_to_bgra_unit
// Undoes PNG row filters on an inflated byte stream and emits BGRA pixels.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in takes one byte of scanline data per word; the first byte of each
//   row is its filter type, and first_of_image restarts at a new image.
//   pixel_out gives one BGRA word per finished pixel, end_of_row on the last
//   pixel of a row. cfg writes image_width (index 0) and color_mode (index 1)
//   and is always ready; write it only while no pixel is outstanding.
//   Throughput is one byte per clock unless pixel_out stalls, set by the
//   single reconstruction stage that feeds each byte's result to the next
//   pixel as left neighbor, and by one line store read and one write per byte.
//   A pixel's last byte goes through the queue and the execute stage into
//   the output register; filter bytes and non-final bytes give no word.
//   Reset clears control state only; the line store is not cleared, since
//   every row reads only what the row before it wrote.
//   When pixel_out stalls, the output register holds the pixel, the back end
//   halts on the next finishing byte and a four-deep queue absorbs input
//   before byte_in.ready drops.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_to_bgra_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic         clk,
  input  logic         rst,
  pngu_byte_if.sink    byte_in,
  pngu_pixel_if.source pixel_out,
  pngu_cfg_if.sink     cfg
);
  import pngu_pkg::*;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Q_W     = $bits(op_t) + COL_W;
  localparam int Q_DEPTH = 4;

  logic             push_valid;
  logic             push_ready;
  op_t              push_op;
  logic [COL_W-1:0] push_col;
  logic             q_valid;
  logic [Q_W-1:0]   q_data;
  op_t              q_op;
  logic [COL_W-1:0] q_col;
  logic             q_pop;

  // front: configuration and byte classification
  pngu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_col   (push_col),
    .push_ready (push_ready)
  );

  // queue between front and back
  pngu_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  ({push_col, push_op}),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  assign q_op  = op_t'(q_data[$bits(op_t)-1:0]);
  assign q_col = q_data[Q_W-1:$bits(op_t)];

  // back: reconstruction, line store and output
  pngu_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_col     (q_col),
    .q_pop     (q_pop),
    .pixel_out (pixel_out)
  );

endmodule

// ===== design/pngu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngu_checker
// Port-level checks on the unfilter unit, bound to its top level.
// ----------------------------------------------------------------------------
module pngu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blue,
  input logic [7:0] out_green,
  input logic [7:0] out_red,
  input logic [7:0] out_alpha,
  input logic       out_end_of_row,
  input logic       cfg_ready
);

  // a stalled pixel word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel word dropped while stalled");

  // a stalled pixel word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_blue) && $stable(out_green) &&
      $stable(out_red) && $stable(out_alpha) && $stable(out_end_of_row))
    else $error("pixel word changed while stalled");

  // reset leaves no pixel pending and a queue that is not full
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid && in_ready)
    else $error("pixel pending or queue full after reset");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind png_scanline_unfilter_to_bgra_unit pngu_checker u_pngu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (byte_in.ready),
  .out_valid      (pixel_out.valid),
  .out_ready      (pixel_out.ready),
  .out_blue       (pixel_out.blue),
  .out_green      (pixel_out.green),
  .out_red        (pixel_out.red),
  .out_alpha      (pixel_out.alpha),
  .out_end_of_row (pixel_out.end_of_row),
  .cfg_ready      (cfg.ready)
);

// ===== bench/png_scanline_unfilter_to_bgra_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter_to_bgra_unit_test
// Feeds filtered PNG scanline bytes into the unit and checks every BGRA word
// against a line-by-line unfilter predictor kept in the bench. Covers all
// row filters, unknown filter codes, new-image restarts, width and mode
// changes between and inside rows, random images with random idling on both
// sides, and long rows at a width setting above the maximum.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_to_bgra_unit_test;
  import pngu_pkg::*;

  localparam int MAX_W = 4096;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       end_of_row;
  } bgra_word_t;

  typedef logic [7:0] byte_list_t[$];

  logic clk;
  logic rst;

  pngu_byte_if  byte_in();
  pngu_pixel_if pixel_out();
  pngu_cfg_if   cfg();

  png_scanline_unfilter_to_bgra_unit #(.MAX_WIDTH(MAX_W)) uut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .pixel_out(pixel_out),
    .cfg(cfg)
  );

  // expected pixels, oldest first
  bgra_word_t expected_pixels[$];

  // unfilter state mirrored in the bench
  logic [7:0]  row_above [MAX_W*4];
  logic [31:0] left_px;
  logic [31:0] upleft_px;
  logic [31:0] build_px;
  filter_t     cur_filter;
  int unsigned col_pos;
  int unsigned lane_pos;
  bit          want_filter;
  bit          top_row;
  logic [12:0] cfg_width;
  color_mode_t cfg_mode;

  int unsigned bytes_sent;
  int unsigned pixels_checked;
  int unsigned error_count;
  int unsigned stall_left;
  bit          idle_on;
  bit          stall_on;

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned eff_width(input logic [12:0] w);
    if (w == 13'd0) return 1;
    if (w > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // mirror one accepted byte, queue a pixel when one completes
  function automatic void unfilter_byte(input logic [7:0] value, input logic new_image);
    int unsigned idx;
    int unsigned bpp;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  pred;
    logic [7:0]  r;
    bgra_word_t  px;
    if (new_image) begin
      want_filter = 1'b1;
      top_row = 1'b1;
    end
    if (want_filter) begin
      cur_filter = (value > 8'd4) ? FLT_NONE : filter_t'(value[2:0]);
      want_filter = 1'b0;
      col_pos = 0;
      lane_pos = 0;
      build_px = '0;
      left_px = '0;
      upleft_px = '0;
      return;
    end
    bpp = int'(cfg_mode) + 1;
    idx = col_pos * 4 + lane_pos;
    a = left_px[8*lane_pos +: 8];
    b = top_row ? 8'd0 : row_above[idx];
    c = upleft_px[8*lane_pos +: 8];
    case (cur_filter)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      FLT_PAETH: pred = paeth_pick(a, b, c);
      default:   pred = 8'd0;
    endcase
    r = value + pred;
    row_above[idx] = r;
    left_px[8*lane_pos +: 8] = r;
    upleft_px[8*lane_pos +: 8] = b;
    build_px[8*lane_pos +: 8] = r;
    if (lane_pos + 1 < bpp) begin
      lane_pos = lane_pos + 1;
      return;
    end
    // pack the finished pixel as bgra
    case (cfg_mode)
      MODE_GRAY: begin
        px.blue = build_px[7:0];
        px.green = build_px[7:0];
        px.red = build_px[7:0];
        px.alpha = OPAQUE_ALPHA;
      end
      MODE_GRAY_ALPHA: begin
        px.blue = build_px[7:0];
        px.green = build_px[7:0];
        px.red = build_px[7:0];
        px.alpha = build_px[15:8];
      end
      MODE_RGB: begin
        px.blue = build_px[23:16];
        px.green = build_px[15:8];
        px.red = build_px[7:0];
        px.alpha = OPAQUE_ALPHA;
      end
      default: begin
        px.blue = build_px[23:16];
        px.green = build_px[15:8];
        px.red = build_px[7:0];
        px.alpha = build_px[31:24];
      end
    endcase
    lane_pos = 0;
    if (col_pos + 1 >= eff_width(cfg_width)) begin
      px.end_of_row = 1'b1;
      want_filter = 1'b1;
      top_row = 1'b0;
      col_pos = 0;
    end else begin
      px.end_of_row = 1'b0;
      col_pos = col_pos + 1;
    end
    expected_pixels.push_back(px);
  endfunction

  function automatic logic [7:0] random_data();
    case ($urandom_range(0, 15))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // pixel sink: check each word, then stall for a random count when stall_on is set
  initial pixel_out.ready = 1'b1;

  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_out.valid && pixel_out.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel word: blue %0d green %0d red %0d alpha %0d eor %0d",
                 pixel_out.blue, pixel_out.green, pixel_out.red, pixel_out.alpha,
                 pixel_out.end_of_row);
          error_count++;
        end else begin
          bgra_word_t want;
          want = expected_pixels.pop_front();
          check_field("blue", want.blue, pixel_out.blue);
          check_field("green", want.green, pixel_out.green);
          check_field("red", want.red, pixel_out.red);
          check_field("alpha", want.alpha, pixel_out.alpha);
          check_field("end_of_row", 8'(want.end_of_row), 8'(pixel_out.end_of_row));
        end
        pixels_checked++;
        stall_left = stall_on ? $urandom_range(0, 6) : 0;
        if (stall_left != 0) pixel_out.ready <= 1'b0;
      end else if (!pixel_out.ready) begin
        if (stall_left <= 1) pixel_out.ready <= 1'b1;
        else stall_left--;
      end
    end
  end

  // send one byte word, valid stays high unless a gap follows
  task automatic send_byte(input logic [7:0] value, input logic new_image);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.data_byte <= value;
    byte_in.first_of_image <= new_image;
    do @(posedge clk); while (!byte_in.ready);
    unfilter_byte(value, new_image);
    bytes_sent++;
  endtask

  task automatic send_row(input logic [7:0] flt, input logic new_image,
                          input byte_list_t data);
    send_byte(flt, new_image);
    foreach (data[i]) send_byte(data[i], 1'b0);
  endtask

  // stop sending, let every pending pixel come out, then let the pipe empty
  task automatic wait_until_drained();
    byte_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write both registers back to back, valid held across the pair
  task automatic set_format(input logic [12:0] width, input color_mode_t mode);
    cfg.valid <= 1'b1;
    cfg.index <= CFG_IMAGE_WIDTH;
    cfg.data <= width;
    do @(posedge clk); while (!cfg.ready);
    cfg_width = width;
    cfg.index <= CFG_COLOR_MODE;
    cfg.data <= {11'd0, mode};
    do @(posedge clk); while (!cfg.ready);
    cfg_mode = mode;
    cfg.valid <= 1'b0;
  endtask

  // each filter type on a two pixel gray image, data extremes included
  task automatic test_filter_types();
    idle_on = 1'b1;
    stall_on = 1'b1;
    set_format(13'd2, MODE_GRAY);
    send_row(8'(FLT_NONE), 1'b1, '{8'd0, 8'd255});
    send_row(8'(FLT_SUB), 1'b0, '{8'd255, 8'd1});
    send_row(8'(FLT_UP), 1'b0, '{8'd128, 8'd200});
    send_row(8'(FLT_AVG), 1'b0, '{8'd255, 8'd255});
    send_row(8'(FLT_PAETH), 1'b0, '{8'd3, 8'd9});
    // unknown code acts as none
    send_row(8'd255, 1'b0, '{8'd1, 8'd1});
    wait_until_drained();
  endtask

  task automatic test_special_cases();
    idle_on = 1'b0;
    stall_on = 1'b1;
    // zero width acts as one pixel
    set_format(13'd0, MODE_RGBA);
    send_row(8'(FLT_SUB), 1'b1, '{8'd1, 8'd2, 8'd3, 8'd4});
    // new image mark drops a partial pixel
    send_row(8'(FLT_UP), 1'b0, '{8'd9, 8'd8});
    send_row(8'(FLT_PAETH), 1'b1, '{8'd10, 8'd20, 8'd30, 8'd40});
    wait_until_drained();
    // mode lowered mid-pixel: the next byte finishes it
    set_format(13'd3, MODE_RGBA);
    send_row(8'(FLT_SUB), 1'b1, '{8'd5, 8'd6, 8'd7, 8'd8, 8'd250, 8'd251});
    wait_until_drained();
    set_format(13'd3, MODE_GRAY_ALPHA);
    send_byte(8'd77, 1'b0);
    wait_until_drained();
    // width lowered mid-row: the next pixel passes it and ends the row
    set_format(13'd2, MODE_GRAY_ALPHA);
    send_byte(8'd33, 1'b0);
    send_byte(8'd44, 1'b0);
    send_row(8'(FLT_UP), 1'b0, '{8'd100, 8'd101, 8'd102, 8'd103});
    wait_until_drained();
  endtask

  // random formats and images, mostly well formed with a few restarts
  task automatic test_random_images();
    int unsigned first_count;
    int unsigned images;
    int unsigned rows;
    int unsigned row_bytes;
    logic [12:0] width;
    color_mode_t mode;
    logic [7:0]  flt;
    bit          cut;
    first_count = bytes_sent;
    while (bytes_sent - first_count < 600) begin
      case ($urandom_range(0, 9))
        0: width = 13'd0;
        1: width = 13'd1;
        2: width = 13'($urandom_range(9, 48));
        default: width = 13'($urandom_range(2, 8));
      endcase
      mode = color_mode_t'($urandom_range(0, 3));
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      set_format(width, mode);
      images = $urandom_range(1, 3);
      row_bytes = eff_width(width) * (int'(mode) + 1);
      repeat (images) begin
        rows = $urandom_range(1, 4);
        cut = 1'b0;
        // no new row once the byte budget is spent
        for (int r = 0; r < rows && !cut && (bytes_sent - first_count < 600); r++) begin
          if ($urandom_range(0, 9) == 0) flt = 8'($urandom_range(5, 255));
          else flt = 8'($urandom_range(0, 4));
          send_byte(flt, r == 0);
          for (int i = 0; i < row_bytes && !cut; i++) begin
            // occasional restart in the middle of a row
            if ($urandom_range(0, 149) == 0) begin
              send_byte(random_data(), 1'b1);
              cut = 1'b1;
            end else begin
              send_byte(random_data(), 1'b0);
            end
          end
        end
      end
      wait_until_drained();
    end
  endtask

  // long rows at a width above the maximum, which acts as the maximum
  task automatic test_widest_rows();
    idle_on = 1'b0;
    stall_on = 1'b0;
    set_format(13'd8191, MODE_GRAY);
    send_byte(8'(FLT_SUB), 1'b1);
    repeat (90) send_byte(random_data(), 1'b0);
    idle_on = 1'b1;
    stall_on = 1'b1;
    // restart partway through the long row
    send_byte(8'(FLT_PAETH), 1'b1);
    repeat (40) send_byte(random_data(), 1'b0);
    wait_until_drained();
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    byte_in.valid = 1'b0;
    byte_in.data_byte = 8'd0;
    byte_in.first_of_image = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_IMAGE_WIDTH;
    cfg.data = '0;
    cfg_width = 13'd1;
    cfg_mode = MODE_RGBA;
    left_px = '0;
    upleft_px = '0;
    build_px = '0;
    cur_filter = FLT_NONE;
    col_pos = 0;
    lane_pos = 0;
    want_filter = 1'b1;
    top_row = 1'b1;
    bytes_sent = 0;
    pixels_checked = 0;
    error_count = 0;
    stall_left = 0;
    idle_on = 1'b0;
    stall_on = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_filter_types();
    test_special_cases();
    test_random_images();
    test_widest_rows();

    wait_until_drained();
    $display("run covered %0d bytes and %0d pixel words: every filter and unknown codes,",
             bytes_sent, pixels_checked);
    $display("all four color modes, restarts, mid-row format changes, widths 0 to 8191");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
